// ===== hdl/bdl_pkg.sv =====
package bdl_pkg;

  localparam int unsigned MaxEntries = 256;

  localparam int unsigned CntW  = 9;
  localparam int unsigned PosW  = 8;
  localparam int unsigned FuncW = 3;
  localparam int unsigned StatW = 2;

  localparam logic [CntW-1:0] CapReset = 9'd256;

  typedef enum logic [FuncW-1:0] {
    FUNC_INS_HEAD  = 3'd0,
    FUNC_INS_TAIL  = 3'd1,
    FUNC_REM_HEAD  = 3'd2,
    FUNC_REM_TAIL  = 3'd3,
    FUNC_READ_HEAD = 3'd4,
    FUNC_READ_TAIL = 3'd5,
    FUNC_READ_IDX  = 3'd6
  } func_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  // What the response stage keeps about one request besides the read word.
  typedef struct packed {
    logic            rd_ok;
    status_e         status;
    logic [CntW-1:0] list_size;
  } result_t;

endpackage

// ===== hdl/bdl_req_if.sv =====
interface bdl_req_if #(
  parameter int unsigned ENTRY_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [bdl_pkg::FuncW-1:0]    func;
  logic [ENTRY_BITS-1:0]        entry_data;
  logic [bdl_pkg::PosW-1:0]     position;

  modport source (output valid, func, entry_data, position, input ready);
  modport sink   (input valid, func, entry_data, position, output ready);
endinterface

// ===== hdl/bdl_rsp_if.sv =====
interface bdl_rsp_if #(
  parameter int unsigned ENTRY_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [ENTRY_BITS-1:0]        read_data;
  logic [bdl_pkg::CntW-1:0]     list_size;
  logic [bdl_pkg::StatW-1:0]    status;

  modport source (output valid, read_data, list_size, status, input ready);
  modport sink   (input valid, read_data, list_size, status, output ready);
endinterface

// ===== hdl/bdl_cfg_if.sv =====
interface bdl_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bdl_pkg::CntW-1:0]     capacity_limit;

  modport source (output valid, capacity_limit, input ready);
  modport sink   (input valid, capacity_limit, output ready);
endinterface

// ===== hdl/bdl_mem.sv =====
module bdl_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bdl_ctrl.sv =====
module bdl_ctrl #(
  parameter int unsigned ENTRY_BITS  = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic [bdl_pkg::FuncW-1:0]              func_i,
  input  logic [ENTRY_BITS-1:0]                  entry_data_i,
  input  logic [bdl_pkg::PosW-1:0]               position_i,
  input  logic                                   cfg_we_i,
  input  logic [bdl_pkg::CntW-1:0]               cfg_data_i,
  output logic                                   mem_we_o,
  output logic                                   mem_re_o,
  output logic [$clog2(bdl_pkg::MaxEntries)-1:0] mem_addr_o,
  output logic [ENTRY_BITS-1:0]                  mem_wdata_o,
  output bdl_pkg::result_t                       result_o
);

  localparam int unsigned PtrW = $clog2(bdl_pkg::MaxEntries);
  localparam int unsigned SumW = ((PtrW > bdl_pkg::CntW) ? PtrW : bdl_pkg::CntW) + 1;

  logic [PtrW-1:0]          head_q, head_d;
  logic [bdl_pkg::CntW-1:0] count_q, count_d;
  logic [bdl_pkg::CntW-1:0] cap_q;
  logic                     full, empty, out_of_range;
  logic                     we, re;
  logic [PtrW-1:0]          addr;
  bdl_pkg::status_e         status;
  logic [bdl_pkg::CntW-1:0] pos_ext;

  // Store index of the entry that sits off entries behind the head. Callers
  // keep off below the store depth, so one conditional subtract wraps it.
  function automatic logic [PtrW-1:0] slot_at(logic [PtrW-1:0] head,
                                               logic [bdl_pkg::CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(head) + SumW'(off);
    if (sum >= SumW'(bdl_pkg::MaxEntries)) begin
      sum = sum - SumW'(bdl_pkg::MaxEntries);
    end
    return sum[PtrW-1:0];
  endfunction

  // A limit above the store depth saturates at the depth.
  assign full = (count_q >= cap_q) || (32'(count_q) >= 32'(bdl_pkg::MaxEntries));
  assign empty = (count_q == '0);
  assign pos_ext = bdl_pkg::CntW'(position_i);
  assign out_of_range = (pos_ext >= count_q);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    we      = 1'b0;
    re      = 1'b0;
    addr    = head_q;
    status  = bdl_pkg::STAT_OK;
    case (bdl_pkg::func_e'(func_i))
      bdl_pkg::FUNC_INS_HEAD: begin
        if (full) begin
          status = bdl_pkg::STAT_FULL;
        end else begin
          head_d  = (head_q == '0) ? PtrW'(bdl_pkg::MaxEntries - 1) : head_q - PtrW'(1);
          addr    = head_d;
          we      = 1'b1;
          count_d = count_q + bdl_pkg::CntW'(1);
        end
      end
      bdl_pkg::FUNC_INS_TAIL: begin
        if (full) begin
          status = bdl_pkg::STAT_FULL;
        end else begin
          addr    = slot_at(head_q, count_q);
          we      = 1'b1;
          count_d = count_q + bdl_pkg::CntW'(1);
        end
      end
      bdl_pkg::FUNC_REM_HEAD: begin
        if (empty) begin
          status = bdl_pkg::STAT_EMPTY;
        end else begin
          head_d  = slot_at(head_q, bdl_pkg::CntW'(1));
          count_d = count_q - bdl_pkg::CntW'(1);
        end
      end
      bdl_pkg::FUNC_REM_TAIL: begin
        if (empty) begin
          status = bdl_pkg::STAT_EMPTY;
        end else begin
          count_d = count_q - bdl_pkg::CntW'(1);
        end
      end
      bdl_pkg::FUNC_READ_HEAD: begin
        if (empty) begin
          status = bdl_pkg::STAT_EMPTY;
        end else begin
          re = 1'b1;
        end
      end
      bdl_pkg::FUNC_READ_TAIL: begin
        if (empty) begin
          status = bdl_pkg::STAT_EMPTY;
        end else begin
          addr = slot_at(head_q, count_q - bdl_pkg::CntW'(1));
          re   = 1'b1;
        end
      end
      bdl_pkg::FUNC_READ_IDX: begin
        if (out_of_range) begin
          status = bdl_pkg::STAT_RANGE;
        end else begin
          addr = slot_at(head_q, pos_ext);
          re   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      cap_q   <= bdl_pkg::CapReset;
    end else begin
      if (accept_i) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  assign mem_we_o           = accept_i & we;
  assign mem_re_o           = accept_i & re;
  assign mem_addr_o         = addr;
  assign mem_wdata_o        = entry_data_i;
  assign result_o.rd_ok     = re;
  assign result_o.status    = status;
  assign result_o.list_size = count_d;

endmodule

// ===== hdl/bounded_double_ended_list.sv =====
// Channel   Role    Payload
// req       sink    func, entry_data, position
// rsp       source  read_data, list_size, status
// cfg       sink    capacity_limit (always ready)
//
// One request per cycle when req.ready is high; rsp.valid rises next cycle.
// Each request makes at most one access to the single-port entry store.
// Reset clears the head pointer and the count and sets the capacity to 256;
// the entry store itself is not cleared and needs no clearing pass.
// A waiting response holds req.ready low unless rsp.ready takes it that cycle.
module bounded_double_ended_list #(
  parameter int unsigned ENTRY_BITS  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdl_req_if.sink   req,
  bdl_rsp_if.source rsp,
  bdl_cfg_if.sink   cfg
);

  localparam int unsigned PtrW = $clog2(bdl_pkg::MaxEntries);

  logic                   accept;
  logic                   mem_we, mem_re;
  logic [PtrW-1:0]        mem_addr;
  logic [ENTRY_BITS-1:0]  mem_wdata, mem_rdata;
  bdl_pkg::result_t       result;
  bdl_pkg::result_t       rsp_q;
  logic                   rsp_valid_q, rsp_valid_d;

  assign req.ready = !rsp_valid_q || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  bdl_ctrl #(
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .func_i       (req.func),
    .entry_data_i (req.entry_data),
    .position_i   (req.position),
    .cfg_we_i     (cfg.valid),
    .cfg_data_i   (cfg.capacity_limit),
    .mem_we_o     (mem_we),
    .mem_re_o     (mem_re),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .result_o     (result)
  );

  bdl_mem #(
    .DEPTH (bdl_pkg::MaxEntries),
    .WIDTH (ENTRY_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (accept) begin
      rsp_valid_d = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= result;
    end
  end

  // The store's read register only loads on an accepted read, so it holds
  // its word for as long as the response waits.
  assign rsp.valid     = rsp_valid_q;
  assign rsp.read_data = rsp_q.rd_ok ? mem_rdata : '0;
  assign rsp.list_size = rsp_q.list_size;
  assign rsp.status    = rsp_q.status;

endmodule
